>>> hdl/ddn_pkg.sv
package ddn_pkg;

    // Calendar limits and defaults
    localparam int YEAR_BASE    = 1900;
    localparam int YEAR_LAST    = 2100;
    localparam int YEAR_DEFAULT = 2025;
    localparam int SERIAL_MIN   = 1;
    localparam int SERIAL_MAX   = 73414;

    // floor(x / 365) = (x * RECIP_365) >> RECIP_SHIFT, exact for x below 2^20
    localparam int RECIP_365   = 735440;
    localparam int RECIP_SHIFT = 28;
    localparam int PROD_W      = 37;

    typedef logic [16:0] serial_t;
    typedef logic [7:0]  yoff_t;   // year minus 1900

    typedef struct packed {
        yoff_t       yoff;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        leap;
    } date_t;

    // Leap rule restricted to 1900..2100: 1900 and 2100 are common years
    function automatic logic leap_off(yoff_t yo);
        return (yo[1:0] == 2'b00) && (yo != 8'd0) && (yo != 8'(YEAR_LAST - YEAR_BASE));
    endfunction

    function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
        case (m)
            4'd2:    return leap ? 5'd29 : 5'd28;
            4'd4:    return 5'd30;
            4'd6:    return 5'd30;
            4'd9:    return 5'd30;
            4'd11:   return 5'd30;
            default: return 5'd31;
        endcase
    endfunction

    // Days in the year before the first of month m
    function automatic logic [8:0] days_before_month(logic [3:0] m, logic leap);
        logic [8:0] base;
        case (m)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + 9'((leap && (m > 4'd2)) ? 1 : 0);
    endfunction

    // Days from 1 January 1900 to 1 January of year 1900+yo (valid up to 2100)
    function automatic serial_t year_start(yoff_t yo);
        serial_t    base;
        logic [5:0] nleap;
        base  = 17'(yo) * 17'd365;
        nleap = (yo == 8'd0) ? 6'd0 : 6'((yo - 8'd1) >> 2);
        return base + 17'(nleap);
    endfunction

    // Normalize year, then month, then day
    function automatic date_t normalize(logic [5:0] d, logic [3:0] m, logic [11:0] y);
        date_t       r;
        logic [11:0] yn;
        yn = ((y < 12'(YEAR_BASE)) || (y > 12'(YEAR_LAST))) ? 12'(YEAR_DEFAULT) : y;
        r.yoff  = 8'(yn - 12'(YEAR_BASE));
        r.month = ((m == 4'd0) || (m > 4'd12)) ? 4'd1 : m;
        r.leap  = leap_off(r.yoff);
        r.day   = ((d == 6'd0) || (d > {1'b0, month_days(r.month, r.leap)})) ? 5'd1 : d[4:0];
        return r;
    endfunction

endpackage

>>> hdl/ddn_date_serial.sv
module ddn_date_serial
    import ddn_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [5:0]  day,
    input  logic [3:0]  month,
    input  logic [11:0] year,
    output serial_t     serial
);

    date_t   date_reg;
    date_t   date_next;
    serial_t serial_reg;
    serial_t serial_next;

    // First stage: normalize the raw date
    assign date_next = normalize(day, month, year);

    // Second stage: add year start, month offset and day
    assign serial_next = year_start(date_reg.yoff)
                       + 17'(days_before_month(date_reg.month, date_reg.leap))
                       + 17'(date_reg.day);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            date_reg   <= date_next;
            serial_reg <= serial_next;
        end
    end

    assign serial = serial_reg;

endmodule

>>> hdl/ddn_serial_to_date.sv
module ddn_serial_to_date
    import ddn_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  serial_t     serial,
    output logic [4:0]  day,
    output logic [3:0]  month,
    output logic [11:0] year
);

    // Stage 1: zero-based day count and its reciprocal product
    serial_t             s0_reg;
    logic [PROD_W-1:0]   prod_reg;
    // Stage 2: year estimate and the starts of it and the year before
    serial_t             s0_d_reg;
    yoff_t               q_reg;
    serial_t             start_q_reg;
    serial_t             start_p_reg;
    // Stage 3: year and day of year
    yoff_t               yoff_reg;
    logic [8:0]          doy_reg;
    logic                leap_reg;
    // Stage 4: month and day
    logic [4:0]          day_reg;
    logic [3:0]          month_reg;
    logic [11:0]         year_reg;

    serial_t             s0_next;
    logic [PROD_W-1:0]   prod_next;
    yoff_t               q_next;
    serial_t             start_q_next;
    serial_t             start_p_next;
    yoff_t               yoff_next;
    serial_t             start_sel;
    logic [8:0]          doy_next;
    logic [3:0]          month_next;
    logic [4:0]          day_next;
    logic [11:0]         year_next;

    // Multiply by the reciprocal of 365
    assign s0_next   = serial - 17'd1;
    assign prod_next = PROD_W'(s0_next) * PROD_W'(RECIP_365);

    // Estimate is the true year or one past it
    assign q_next       = prod_reg[RECIP_SHIFT +: 8];
    assign start_q_next = year_start(q_next);
    assign start_p_next = (q_next == 8'd0) ? 17'd0 : year_start(q_next - 8'd1);

    // Step back one year when the estimate starts after the day
    always_comb
    begin
        if (start_q_reg > s0_d_reg)
        begin
            yoff_next = q_reg - 8'd1;
            start_sel = start_p_reg;
        end
        else
        begin
            yoff_next = q_reg;
            start_sel = start_q_reg;
        end
        doy_next = 9'(s0_d_reg - start_sel);
    end

    // Pick the last month whose first day is not after the day of year
    always_comb
    begin
        month_next = 4'd1;
        for (int m = 2; m <= 12; m++)
        begin
            if (doy_reg >= days_before_month(4'(m), leap_reg))
                month_next = 4'(m);
        end
        day_next  = 5'(doy_reg - days_before_month(month_next, leap_reg) + 9'd1);
        year_next = 12'(YEAR_BASE) + 12'(yoff_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg      <= s0_next;
            prod_reg    <= prod_next;
            s0_d_reg    <= s0_reg;
            q_reg       <= q_next;
            start_q_reg <= start_q_next;
            start_p_reg <= start_p_next;
            yoff_reg    <= yoff_next;
            doy_reg     <= doy_next;
            leap_reg    <= leap_off(yoff_next);
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
        end
    end

    assign day   = day_reg;
    assign month = month_reg;
    assign year  = year_reg;

endmodule

>>> hdl/date_day_number_convert.sv
// Channel   Dir  tdata (low bit up)                                  tuser
// s_axis    in   day_a 6, month_a 4, year_a 12, day_b 6, month_b 4,  -
//                year_b 12, offset 18 (signed), 2 zero bits
// m_axis    out  serial_a 17, serial_b 17, difference 18 (signed),   shift_out_of_range
//                shifted_day 5, shifted_month 4, shifted_year 12, 7 zero bits
//
// Seven register stages: two for normalize and serial, one for difference and
// shift clamp, four for the serial-to-date path (reciprocal multiply, year pick,
// month search). One transfer is taken every cycle while the pipe is not held.
// The whole pipe advances together; it holds when the output stage is full and
// m_axis_tready is low, and s_axis_tready follows that same enable.
// Reset clears all valid bits.
module date_day_number_convert
    import ddn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // day_a, month_a, year_a, day_b, month_b, year_b, offset
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // serial_a, serial_b, difference, shifted_day,
                                        // shifted_month, shifted_year
    output logic        m_axis_tuser    // shift_out_of_range
);

    localparam int STAGES = 7;
    localparam int TAIL   = 5;

    typedef struct packed {
        serial_t     serial_a;
        serial_t     serial_b;
        logic [17:0] difference;
        logic        out_of_range;
    } carry_t;

    logic               en;
    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  valid_next;
    logic [17:0]        offset_reg [2];
    serial_t            serial_a;
    serial_t            serial_b;
    serial_t            shift_reg;
    serial_t            shift_next;
    carry_t             carry_reg [TAIL];
    carry_t             carry_next;
    logic signed [18:0] shift_sum;
    logic [4:0]         shifted_day;
    logic [3:0]         shifted_month;
    logic [11:0]        shifted_year;

    // Advance everything unless the output stage is stuck
    assign en            = !valid_reg[STAGES-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign valid_next    = {valid_reg[STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // Date to serial for both dates
    ddn_date_serial u_serial_a
    (
        .clk    (clk),
        .en     (en),
        .day    (s_axis_tdata[5:0]),
        .month  (s_axis_tdata[9:6]),
        .year   (s_axis_tdata[21:10]),
        .serial (serial_a)
    );

    ddn_date_serial u_serial_b
    (
        .clk    (clk),
        .en     (en),
        .day    (s_axis_tdata[27:22]),
        .month  (s_axis_tdata[31:28]),
        .year   (s_axis_tdata[43:32]),
        .serial (serial_b)
    );

    // Difference, shift and clamp
    always_comb
    begin
        shift_sum = $signed({2'b00, serial_a}) + $signed({offset_reg[1][17], offset_reg[1]});
        carry_next.serial_a     = serial_a;
        carry_next.serial_b     = serial_b;
        carry_next.difference   = {1'b0, serial_a} - {1'b0, serial_b};
        carry_next.out_of_range = 1'b0;
        shift_next              = 17'(shift_sum);
        if (shift_sum < 19'sd1)
        begin
            shift_next              = 17'(SERIAL_MIN);
            carry_next.out_of_range = 1'b1;
        end
        else if (shift_sum > 19'(SERIAL_MAX))
        begin
            shift_next              = 17'(SERIAL_MAX);
            carry_next.out_of_range = 1'b1;
        end
    end

    // Hold the offset beside the serial stages and carry results down the tail
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            offset_reg[0] <= s_axis_tdata[61:44];
            offset_reg[1] <= offset_reg[0];
            shift_reg     <= shift_next;
            carry_reg[0]  <= carry_next;
            for (int i = 1; i < TAIL; i++)
                carry_reg[i] <= carry_reg[i-1];
        end
    end

    // Shifted serial back to a date
    ddn_serial_to_date u_to_date
    (
        .clk    (clk),
        .en     (en),
        .serial (shift_reg),
        .day    (shifted_day),
        .month  (shifted_month),
        .year   (shifted_year)
    );

    assign m_axis_tvalid = valid_reg[STAGES-1];
    assign m_axis_tdata  = {7'd0, shifted_year, shifted_month, shifted_day,
                            carry_reg[TAIL-1].difference, carry_reg[TAIL-1].serial_b,
                            carry_reg[TAIL-1].serial_a};
    assign m_axis_tuser  = carry_reg[TAIL-1].out_of_range;

endmodule

>>> hdl/ddn_checker.sv
module ddn_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // Output holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("output transfer changed while stalled");

    // Input side is ready exactly when the output stage can move
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stage");

    // Difference matches the two serials
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[51:34] ==
                          ({1'b0, m_axis_tdata[16:0]} - {1'b0, m_axis_tdata[33:17]}))
        else $error("difference does not match serials");

    // A clamped shift lands on the first or last day of the range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[56:52] == 5'd1 && m_axis_tdata[60:57] == 4'd1
             && m_axis_tdata[72:61] == 12'd1900)
            || (m_axis_tdata[56:52] == 5'd31 && m_axis_tdata[60:57] == 4'd12
                && m_axis_tdata[72:61] == 12'd2100))
        else $error("clamped shift is not at a range end");

endmodule

bind date_day_number_convert ddn_checker u_ddn_checker (.*);
